// ----- design/slt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// types, token codes, keyword table and the per-byte lexing functions
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int KW_MAX = 12;
    localparam int KW_NUM = 22;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_WORD  = 4'd1,
        M_AT    = 4'd2,
        M_INT   = 4'd3,
        M_FRAC  = 4'd4,
        M_EXPE  = 4'd5,
        M_EXPS  = 4'd6,
        M_EXPD  = 4'd7,
        M_LT    = 4'd8,
        M_GT    = 4'd9,
        M_EQ    = 4'd10,
        M_SLASH = 4'd11,
        M_STAR  = 4'd12,
        M_STR   = 4'd13
    } t_mode;

    localparam logic [5:0] K_END    = 6'd0;
    localparam logic [5:0] K_ERR    = 6'd1;
    localparam logic [5:0] K_PLAIN  = 6'd2;
    localparam logic [5:0] K_STR    = 6'd3;
    localparam logic [5:0] K_KW0    = 6'd4;
    localparam logic [5:0] K_NE     = 6'd26;
    localparam logic [5:0] K_LE     = 6'd27;
    localparam logic [5:0] K_GE     = 6'd28;
    localparam logic [5:0] K_EQ     = 6'd29;
    localparam logic [5:0] K_COPEN  = 6'd30;
    localparam logic [5:0] K_CCLOSE = 6'd31;
    localparam logic [5:0] K_CHAR   = 6'd32;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_UE    = 8'h45;

    // keywords padded with spaces to the full width, first character highest
    localparam logic [KW_MAX*8-1:0] KW_TXT [KW_NUM] = '{
        "ID          ", "AS          ", "OR          ", "AND         ",
        "NOT         ", "DIV         ", "MOD         ", "AVG         ",
        "MIN         ", "MAX         ", "SUM         ", {"GROUP", "_CONCAT"},
        "GROUPBY     ", "COUNT       ", "DISTINCT    ", "WEIGHT      ",
        "OPTION      ", "IS          ", "NULL        ", "FOR         ",
        "IN          ", "RAND        "
    };
    localparam logic [4:0] KW_LEN [KW_NUM] = '{
        5'd2, 5'd2, 5'd2, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3,
        5'd12, 5'd7, 5'd5, 5'd8, 5'd6, 5'd6, 5'd2, 5'd4, 5'd3, 5'd2, 5'd4
    };

    typedef struct packed {
        t_mode                      mode;
        logic [KW_MAX-1:0][7:0]     wbuf;
        logic [4:0]                 wlen;
        logic [15:0]                tstart;
        logic [7:0]                 pend0;
        logic [7:0]                 pend1;
        logic                       esc;
    } t_lex;

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  ch;
        logic [15:0] s;
        logic [15:0] e;
    } t_tok;

    typedef struct packed {
        t_tok [2:0] tok;
        logic [1:0] cnt;
    } t_res;

    typedef struct packed {
        t_lex st;
        t_res res;
        logic again;
        logic err;
    } t_step;

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_attr(logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A) || (c == 8'h5F);
    endfunction

    function automatic t_res emit(t_res r, logic [5:0] kind, logic [7:0] ch,
                                  logic [15:0] s, logic [15:0] e);
        t_res o;
        o = r;
        if (r.cnt != 2'd3) begin
            o.tok[r.cnt] = '{kind: kind, ch: ch, s: s, e: e};
            o.cnt        = r.cnt + 2'd1;
        end
        return o;
    endfunction

    function automatic t_lex word_add(t_lex s, logic [7:0] c);
        t_lex o;
        o = s;
        if (s.wlen < 5'(KW_MAX)) o.wbuf[s.wlen[3:0]] = c;
        if (s.wlen <= 5'(KW_MAX)) o.wlen = s.wlen + 5'd1;
        return o;
    endfunction

    function automatic logic [5:0] kw_kind(t_lex s);
        logic [5:0] kind;
        logic       hit;
        logic [7:0] b;
        kind = K_PLAIN;
        for (int i = KW_NUM - 1; i >= 0; i--) begin
            hit = (s.wlen == KW_LEN[i]);
            for (int j = 0; j < KW_MAX; j++) begin
                b = s.wbuf[j];
                if (b >= 8'h61 && b <= 8'h7A) b = b - 8'd32;
                if (5'(j) < s.wlen && b != KW_TXT[i][(KW_MAX-1-j)*8 +: 8]) hit = 1'b0;
            end
            if (hit) kind = K_KW0 + 6'(i);
        end
        return kind;
    endfunction

    // one pass through the mode switch; again asks for the byte to be seen once more
    function automatic t_step lex_step(t_lex s, logic [7:0] c, logic [15:0] p, t_res r);
        t_step       o;
        logic [15:0] pm1;
        logic [15:0] pm2;
        logic [15:0] ts1;
        o.st    = s;
        o.res   = r;
        o.again = 1'b0;
        o.err   = 1'b0;
        pm1     = p - 16'd1;
        pm2     = p - 16'd2;
        ts1     = s.tstart + 16'd1;
        unique case (s.mode)
            M_IDLE: begin
                if (c != CH_NUL && !is_space(c)) begin
                    o.st.tstart = p;
                    if (is_digit(c)) begin
                        o.st.mode = M_INT;
                    end else if (is_attr(c) || c == CH_AT) begin
                        o.st.wbuf[0] = c;
                        o.st.wlen    = 5'd1;
                        o.st.mode    = (c == CH_AT) ? M_AT : M_WORD;
                    end else begin
                        priority case (c)
                            CH_LT:    o.st.mode = M_LT;
                            CH_GT:    o.st.mode = M_GT;
                            CH_EQ:    o.st.mode = M_EQ;
                            CH_SLASH: o.st.mode = M_SLASH;
                            CH_STAR:  o.st.mode = M_STAR;
                            CH_QUOTE: begin
                                o.st.mode = M_STR;
                                o.st.esc  = 1'b0;
                            end
                            default:  o.res = emit(r, K_CHAR, c, p, p + 16'd1);
                        endcase
                    end
                end
            end
            M_WORD: begin
                if (is_attr(c)) begin
                    o.st = word_add(s, c);
                end else begin
                    o.res     = emit(r, kw_kind(s), 8'd0, s.tstart, p);
                    o.st.mode = M_IDLE;
                    o.again   = 1'b1;
                end
            end
            M_AT: begin
                if (is_attr(c) && !is_digit(c)) begin
                    o.st      = word_add(s, c);
                    o.st.mode = M_WORD;
                end else begin
                    o.res     = emit(r, K_CHAR, CH_AT, s.tstart, ts1);
                    o.st.mode = M_IDLE;
                    o.again   = 1'b1;
                end
            end
            M_INT, M_FRAC: begin
                if (is_digit(c)) begin
                    o.st.mode = s.mode;
                end else if (c == CH_DOT && s.mode == M_INT) begin
                    o.st.mode = M_FRAC;
                end else if (c == CH_LE || c == CH_UE) begin
                    o.st.pend0 = c;
                    o.st.mode  = M_EXPE;
                end else begin
                    o.res     = emit(r, K_PLAIN, 8'd0, s.tstart, p);
                    o.st.mode = M_IDLE;
                    o.again   = 1'b1;
                end
            end
            M_EXPE: begin
                if (is_digit(c)) begin
                    o.st.mode = M_EXPD;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    o.st.pend1 = c;
                    o.st.mode  = M_EXPS;
                end else begin
                    // the e starts an identifier of its own
                    o.res        = emit(r, K_PLAIN, 8'd0, s.tstart, pm1);
                    o.st.tstart  = pm1;
                    o.st.wbuf[0] = s.pend0;
                    o.st.wlen    = 5'd1;
                    o.st.mode    = M_WORD;
                    o.again      = 1'b1;
                end
            end
            M_EXPS: begin
                if (is_digit(c)) begin
                    o.st.mode = M_EXPD;
                end else begin
                    // number, then the e as identifier, then the sign as a char
                    o.res        = emit(r, K_PLAIN, 8'd0, s.tstart, pm2);
                    o.res        = emit(o.res, K_PLAIN, 8'd0, pm2, pm1);
                    o.res        = emit(o.res, K_CHAR, s.pend1, pm1, p);
                    o.st.tstart  = pm1;
                    o.st.wbuf[0] = s.pend0;
                    o.st.wlen    = 5'd1;
                    o.st.mode    = M_IDLE;
                    o.again      = 1'b1;
                end
            end
            M_EXPD: begin
                if (!is_digit(c)) begin
                    o.res     = emit(r, K_PLAIN, 8'd0, s.tstart, p);
                    o.st.mode = M_IDLE;
                    o.again   = 1'b1;
                end
            end
            M_LT: begin
                o.st.mode = M_IDLE;
                if (c == CH_GT) o.res = emit(r, K_NE, 8'd0, s.tstart, p + 16'd1);
                else if (c == CH_EQ) o.res = emit(r, K_LE, 8'd0, s.tstart, p + 16'd1);
                else begin
                    o.res   = emit(r, K_CHAR, CH_LT, s.tstart, ts1);
                    o.again = 1'b1;
                end
            end
            M_GT: begin
                o.st.mode = M_IDLE;
                if (c == CH_EQ) o.res = emit(r, K_GE, 8'd0, s.tstart, p + 16'd1);
                else begin
                    o.res   = emit(r, K_CHAR, CH_GT, s.tstart, ts1);
                    o.again = 1'b1;
                end
            end
            M_EQ: begin
                o.st.mode = M_IDLE;
                if (c == CH_EQ) o.res = emit(r, K_EQ, 8'd0, s.tstart, p + 16'd1);
                else begin
                    o.res   = emit(r, K_EQ, 8'd0, s.tstart, ts1);
                    o.again = 1'b1;
                end
            end
            M_SLASH: begin
                o.st.mode = M_IDLE;
                if (c == CH_STAR) o.res = emit(r, K_COPEN, 8'd0, s.tstart, p + 16'd1);
                else begin
                    o.res   = emit(r, K_CHAR, CH_SLASH, s.tstart, ts1);
                    o.again = 1'b1;
                end
            end
            M_STAR: begin
                o.st.mode = M_IDLE;
                if (c == CH_SLASH) o.res = emit(r, K_CCLOSE, 8'd0, s.tstart, p + 16'd1);
                else begin
                    o.res   = emit(r, K_CHAR, CH_STAR, s.tstart, ts1);
                    o.again = 1'b1;
                end
            end
            M_STR: begin
                if (c == CH_NUL) begin
                    o.res     = emit(r, K_ERR, 8'd0, s.tstart, p);
                    o.err     = 1'b1;
                    o.st.mode = M_IDLE;
                end else if (s.esc) begin
                    o.st.esc = 1'b0;
                end else if (c == CH_BSL) begin
                    o.st.esc = 1'b1;
                end else if (c == CH_QUOTE) begin
                    o.res     = emit(r, K_STR, 8'd0, s.tstart, p + 16'd1);
                    o.st.mode = M_IDLE;
                end
            end
            default: begin
                o.st.mode = M_IDLE;
                o.again   = 1'b1;
            end
        endcase
        return o;
    endfunction

    // a byte passes the mode switch at most three times
    function automatic t_step lex_byte(t_lex s, logic [7:0] c, logic [15:0] p, t_res r);
        t_step o;
        t_step t;
        o = lex_step(s, c, p, r);
        for (int k = 0; k < 2; k++) begin
            if (o.again) begin
                t     = lex_step(o.st, c, p, o.res);
                t.err = t.err | o.err;
                o     = t;
            end
        end
        return o;
    endfunction

endpackage

// ----- design/slt_lexer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_lexer
// lexer state registers and the combinational token logic for one byte
// ----------------------------------------------------------------------------
module slt_lexer #(
    parameter int MAX_TEXT_LEN = 65535
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic          i_eot,
    output slt_pkg::t_res o_res
);
    import slt_pkg::*;

    localparam int PW = $clog2(MAX_TEXT_LEN + 1);

    t_lex          r_st;
    t_lex          n_st;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;

    t_step       a;
    t_step       b;
    t_res        res;
    logic [15:0] q16;
    logic        fin;

    always_comb begin
        res   = '0;
        n_st  = r_st;
        n_pos = r_pos;
        fin   = 1'b0;
        q16   = 16'(r_pos);
        a     = '0;
        b     = '0;
        if (i_byte != CH_NUL) begin
            a     = lex_byte(r_st, i_byte, 16'(r_pos), res);
            n_st  = a.st;
            res   = a.res;
            n_pos = (r_pos < PW'(MAX_TEXT_LEN)) ? r_pos + PW'(1) : r_pos;
            fin   = i_eot;
            q16   = 16'(n_pos);
        end else begin
            fin = 1'b1;
        end
        if (fin) begin
            b    = lex_byte(n_st, CH_NUL, q16, res);
            res  = b.res;
            if (!b.err) res = emit(res, K_END, 8'd0, q16, q16);
            n_st        = b.st;
            n_st.mode   = M_IDLE;
            n_st.wlen   = 5'd0;
            n_st.tstart = 16'd0;
            n_st.esc    = 1'b0;
            n_pos       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= '0;
            r_pos <= '0;
        end else if (i_accept) begin
            r_st  <= n_st;
            r_pos <= n_pos;
        end
    end

    assign o_res = res;

endmodule

// ----- design/slt_out_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_out_queue
// result register holding up to three tokens, handed out one per request
// ----------------------------------------------------------------------------
module slt_out_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  slt_pkg::t_res i_res,
    input  logic          i_ready,
    output logic          o_valid,
    output logic          o_last,
    output slt_pkg::t_tok o_tok,
    output logic          o_free
);
    import slt_pkg::*;

    t_tok [2:0] r_tok;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [1:0] r_head;
    logic [1:0] n_head;
    logic       pop;

    assign pop    = (r_cnt != 2'd0) && i_ready;
    // free when empty or when the final token leaves in this cycle
    assign o_free = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    always_comb begin
        n_cnt  = r_cnt;
        n_head = r_head;
        if (i_load) begin
            n_cnt  = i_res.cnt;
            n_head = 2'd0;
        end else if (pop) begin
            n_cnt  = r_cnt - 2'd1;
            n_head = r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 2'd0;
        end else begin
            r_cnt  <= n_cnt;
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_tok <= i_res.tok;
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_last  = (r_cnt == 2'd1);
    assign o_tok   = r_tok[r_head];

endmodule

// ----- design/select_list_tokenizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// select_list_tokenizer_top
// streaming lexer for select-list text, one byte in, up to three tokens out
// ----------------------------------------------------------------------------
// usage
//   slave side: one text byte per request in s tdata, tlast marks the final
//   byte; a zero byte also ends the text. after the end an end token (or an
//   error token for an open string) follows and offsets restart at zero.
//   master side: one token per request, tlast set on the last token that a
//   given byte produced. bytes that close no token produce nothing.
// flow
//   a token appears in the cycle after the byte that completes it. a byte
//   that yields at most one token is taken every cycle while the master side
//   is ready; a byte that yields more holds the slave side until its last token
//   leaves the three-entry result register, which drains one token per ready cycle.
// reset
//   synchronous active low; clears the lexer state, the offset counter and
//   empties the result register.
// stalls
//   while the master side is stalled, the result register holds its tokens
//   and the slave side accepts a byte only once the register is empty.
// ----------------------------------------------------------------------------
module select_list_tokenizer_top #(
    parameter int MAX_TEXT_LEN = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [5:0] token_kind, [13:6] char_value,
                                     // [29:14] start_offset, [45:30] end_offset
    output logic        o_m_tlast
);
    import slt_pkg::*;

    logic accept;
    logic free;
    t_res res;
    t_tok tok;

    assign o_s_tready = free;
    assign accept     = i_s_tvalid && free;

    slt_lexer #(
        .MAX_TEXT_LEN(MAX_TEXT_LEN)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_byte  (i_s_tdata),
        .i_eot   (i_s_tlast),
        .o_res   (res)
    );

    slt_out_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (accept),
        .i_res  (res),
        .i_ready(i_m_tready),
        .o_valid(o_m_tvalid),
        .o_last (o_m_tlast),
        .o_tok  (tok),
        .o_free (free)
    );

    assign o_m_tdata = {2'b00, tok.e, tok.s, tok.ch, tok.kind};

endmodule

// ----- design/slt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_checker
// port-level checks on the token stream
// ----------------------------------------------------------------------------
module slt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic        o_m_tlast
);
    import slt_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("token dropped while stalled");

    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[5:0] != K_CHAR |-> o_m_tdata[13:6] == 8'd0)
        else $error("char value on a multi-byte token");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[5:0] == K_END |-> o_m_tlast &&
        o_m_tdata[29:14] == o_m_tdata[45:30])
        else $error("end token malformed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("request taken with tokens pending");

endmodule

bind select_list_tokenizer_top slt_checker u_slt_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tlast (o_m_tlast)
);

// ----- verif/tb_select_list_tokenizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_select_list_tokenizer_top
// streams select-list text into the tokenizer and compares every token with
// an in-bench lexer model; directed texts first, then random token sequences
// under several idle and stall mixes
// ----------------------------------------------------------------------------
module tb_select_list_tokenizer_top;
    import slt_pkg::*;

    typedef struct {
        logic [5:0]  kind;
        logic [7:0]  ch;
        logic [15:0] s;
        logic [15:0] e;
        logic        last;
    } t_token;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] text_byte
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;   // [5:0] kind, [13:6] char, [29:14] start, [45:30] end
    logic        o_m_tlast;

    select_list_tokenizer_top dut (.*);

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // lexer model state
    t_mode      lx_mode;
    logic [7:0] lx_word [KW_MAX];
    int         lx_wlen;
    int         lx_tstart;
    int         lx_pos;
    logic [7:0] lx_pend [2];
    bit         lx_esc;
    bit         lx_err;
    t_token     step_tok [3];
    int         step_cnt;

    t_token     tokens_due [$];
    int         fails;
    int         idle_pct;
    int         stall_pct;
    int         quiet_cycles;

    string kw_names [KW_NUM] = '{"ID", "AS", "OR", "AND", "NOT", "DIV", "MOD", "AVG",
        "MIN", "MAX", "SUM", {string'("GROUP"), "_CONCAT"}, "GROUPBY", "COUNT", "DISTINCT",
        "WEIGHT", "OPTION", "IS", "NULL", "FOR", "IN", "RAND"};

    function automatic bit sp(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic bit dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit idc(logic [7:0] c);
        return dig(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic void put_tok(logic [5:0] k, logic [7:0] ch, int s, int e);
        if (step_cnt < 3) begin
            step_tok[step_cnt] = '{kind: k, ch: ch, s: s[15:0], e: e[15:0], last: 1'b0};
            step_cnt++;
        end
    endfunction

    function automatic void add_word(logic [7:0] c);
        if (lx_wlen < KW_MAX) lx_word[lx_wlen] = c;
        if (lx_wlen <= KW_MAX) lx_wlen++;
    endfunction

    function automatic void close_word(int e);
        logic [5:0] k;
        logic [7:0] b;
        bit         hit;
        k = K_PLAIN;
        for (int i = 0; i < KW_NUM && k == K_PLAIN; i++) begin
            if (lx_wlen == kw_names[i].len() && lx_wlen <= KW_MAX) begin
                hit = 1'b1;
                for (int j = 0; j < lx_wlen; j++) begin
                    b = lx_word[j];
                    if (b >= "a" && b <= "z") b = b - 8'd32;
                    if (b != kw_names[i][j]) hit = 1'b0;
                end
                if (hit) k = K_KW0 + 6'(i);
            end
        end
        put_tok(k, 8'd0, lx_tstart, e);
    endfunction

    function automatic int pback(int p, int n);
        return p >= n ? p - n : 0;
    endfunction

    // one byte through the lexer; a token closed by a byte outside it sends the byte round again
    function automatic void lex_byte(logic [7:0] c, int p);
        bit again;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (lx_mode)
                M_IDLE: begin
                    if (c != CH_NUL && !sp(c)) begin
                        lx_tstart = p;
                        if (dig(c)) lx_mode = M_INT;
                        else if (idc(c) || c == CH_AT) begin
                            lx_wlen = 0;
                            add_word(c);
                            lx_mode = (c == CH_AT) ? M_AT : M_WORD;
                        end else if (c == CH_LT) lx_mode = M_LT;
                        else if (c == CH_GT) lx_mode = M_GT;
                        else if (c == CH_EQ) lx_mode = M_EQ;
                        else if (c == CH_SLASH) lx_mode = M_SLASH;
                        else if (c == CH_STAR) lx_mode = M_STAR;
                        else if (c == CH_QUOTE) begin
                            lx_mode = M_STR;
                            lx_esc  = 1'b0;
                        end else put_tok(K_CHAR, c, p, p + 1);
                    end
                end
                M_WORD: begin
                    if (idc(c)) add_word(c);
                    else begin
                        close_word(p);
                        lx_mode = M_IDLE;
                        again   = 1'b1;
                    end
                end
                M_AT: begin
                    if (idc(c) && !dig(c)) begin
                        add_word(c);
                        lx_mode = M_WORD;
                    end else begin
                        put_tok(K_CHAR, CH_AT, lx_tstart, lx_tstart + 1);
                        lx_mode = M_IDLE;
                        again   = 1'b1;
                    end
                end
                M_INT, M_FRAC: begin
                    if (dig(c)) ;
                    else if (c == CH_DOT && lx_mode == M_INT) lx_mode = M_FRAC;
                    else if (c == CH_LE || c == CH_UE) begin
                        lx_pend[0] = c;
                        lx_mode    = M_EXPE;
                    end else begin
                        put_tok(K_PLAIN, 8'd0, lx_tstart, p);
                        lx_mode = M_IDLE;
                        again   = 1'b1;
                    end
                end
                M_EXPE: begin
                    if (dig(c)) lx_mode = M_EXPD;
                    else if (c == CH_PLUS || c == CH_MINUS) begin
                        lx_pend[1] = c;
                        lx_mode    = M_EXPS;
                    end else begin
                        put_tok(K_PLAIN, 8'd0, lx_tstart, pback(p, 1));
                        lx_mode = M_IDLE;
                        lex_byte(lx_pend[0], pback(p, 1));
                        again = 1'b1;
                    end
                end
                M_EXPS: begin
                    if (dig(c)) lx_mode = M_EXPD;
                    else begin
                        put_tok(K_PLAIN, 8'd0, lx_tstart, pback(p, 2));
                        lx_mode = M_IDLE;
                        lex_byte(lx_pend[0], pback(p, 2));
                        lex_byte(lx_pend[1], pback(p, 1));
                        again = 1'b1;
                    end
                end
                M_EXPD: begin
                    if (!dig(c)) begin
                        put_tok(K_PLAIN, 8'd0, lx_tstart, p);
                        lx_mode = M_IDLE;
                        again   = 1'b1;
                    end
                end
                M_LT: begin
                    lx_mode = M_IDLE;
                    if (c == CH_GT) put_tok(K_NE, 8'd0, lx_tstart, p + 1);
                    else if (c == CH_EQ) put_tok(K_LE, 8'd0, lx_tstart, p + 1);
                    else begin
                        put_tok(K_CHAR, CH_LT, lx_tstart, lx_tstart + 1);
                        again = 1'b1;
                    end
                end
                M_GT: begin
                    lx_mode = M_IDLE;
                    if (c == CH_EQ) put_tok(K_GE, 8'd0, lx_tstart, p + 1);
                    else begin
                        put_tok(K_CHAR, CH_GT, lx_tstart, lx_tstart + 1);
                        again = 1'b1;
                    end
                end
                M_EQ: begin
                    lx_mode = M_IDLE;
                    if (c == CH_EQ) put_tok(K_EQ, 8'd0, lx_tstart, p + 1);
                    else begin
                        put_tok(K_EQ, 8'd0, lx_tstart, lx_tstart + 1);
                        again = 1'b1;
                    end
                end
                M_SLASH: begin
                    lx_mode = M_IDLE;
                    if (c == CH_STAR) put_tok(K_COPEN, 8'd0, lx_tstart, p + 1);
                    else begin
                        put_tok(K_CHAR, CH_SLASH, lx_tstart, lx_tstart + 1);
                        again = 1'b1;
                    end
                end
                M_STAR: begin
                    lx_mode = M_IDLE;
                    if (c == CH_SLASH) put_tok(K_CCLOSE, 8'd0, lx_tstart, p + 1);
                    else begin
                        put_tok(K_CHAR, CH_STAR, lx_tstart, lx_tstart + 1);
                        again = 1'b1;
                    end
                end
                M_STR: begin
                    if (c == CH_NUL) begin
                        put_tok(K_ERR, 8'd0, lx_tstart, p);
                        lx_err  = 1'b1;
                        lx_mode = M_IDLE;
                    end else if (lx_esc) lx_esc = 1'b0;
                    else if (c == CH_BSL) lx_esc = 1'b1;
                    else if (c == CH_QUOTE) begin
                        put_tok(K_STR, 8'd0, lx_tstart, p + 1);
                        lx_mode = M_IDLE;
                    end
                end
                default: lx_mode = M_IDLE;
            endcase
        end
    endfunction

    function automatic void close_text(int q);
        lex_byte(CH_NUL, q);
        if (!lx_err) put_tok(K_END, 8'd0, q, q);
        lx_mode   = M_IDLE;
        lx_wlen   = 0;
        lx_tstart = 0;
        lx_pos    = 0;
        lx_esc    = 1'b0;
    endfunction

    // tokens that one accepted byte should produce, queued in order
    function automatic void predict_tokens(logic [7:0] c, logic eot);
        int p;
        p        = lx_pos;
        step_cnt = 0;
        lx_err   = 1'b0;
        if (c != CH_NUL) begin
            lex_byte(c, p);
            lx_pos = (p < 65535) ? p + 1 : 65535;
            if (eot) close_text(lx_pos);
        end else close_text(p);
        for (int i = 0; i < step_cnt; i++) begin
            step_tok[i].last = (i == step_cnt - 1);
            tokens_due.push_back(step_tok[i]);
        end
    endfunction

    task automatic send_byte(logic [7:0] c, logic eot);
        int gap;
        gap = 0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= eot;
        do @(posedge i_clk); while (!o_s_tready);
        predict_tokens(c, eot);
    endtask

    // text ends either with tlast on its final byte or with a zero byte
    task automatic send_text(string t, bit by_last);
        for (int i = 0; i < t.len(); i++)
            send_byte(t[i], by_last && i == t.len() - 1);
        if (!by_last || t.len() == 0) send_byte(CH_NUL, 1'b0);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
        if (!i_rst_n || ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge i_clk) begin
        t_token x;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (tokens_due.size() == 0) begin
                $error("token with none due: tdata %h", o_m_tdata);
                fails++;
            end else begin
                x = tokens_due.pop_front();
                if (o_m_tdata[5:0] !== x.kind) begin
                    $error("token_kind expected %0d got %0d", x.kind, o_m_tdata[5:0]);
                    fails++;
                end
                if (o_m_tdata[13:6] !== x.ch) begin
                    $error("char_value expected %0d got %0d", x.ch, o_m_tdata[13:6]);
                    fails++;
                end
                if (o_m_tdata[29:14] !== x.s) begin
                    $error("start_offset expected %0d got %0d", x.s, o_m_tdata[29:14]);
                    fails++;
                end
                if (o_m_tdata[45:30] !== x.e) begin
                    $error("end_offset expected %0d got %0d", x.e, o_m_tdata[45:30]);
                    fails++;
                end
                if (o_m_tlast !== x.last) begin
                    $error("last_in_run expected %0d got %0d", x.last, o_m_tlast);
                    fails++;
                end
            end
        end
    end

    initial begin
        wait (i_rst_n);
        while (quiet_cycles < 4000) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic test_keywords();
        send_text({kw_names[11].tolower(), " Or abcdefghijklm"}, 1'b1);
    endtask

    task automatic test_operators();
        send_text("a<>b<=c>=d==e/*f*/<", 1'b1);
        send_text("@x @1=", 1'b0);
    endtask

    task automatic test_numbers();
        send_text("7.5e10 4e-x 8e;", 1'b0);
        send_text("3e-", 1'b1);
    endtask

    task automatic test_strings();
        send_text("'it\\'s' 'a\\\\'", 1'b1);
        send_text("'open", 1'b0);
        send_text("\t x", 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("", 1'b0);
    endtask

    function automatic string rand_word();
        string w;
        int    n;
        w = "";
        n = $urandom_range(1, 14);
        for (int i = 0; i < n; i++)
            case ($urandom_range(3))
                0: w = {w, string'(8'("a" + $urandom_range(25)))};
                1: w = {w, string'(8'("A" + $urandom_range(25)))};
                2: w = {w, string'(8'("0" + $urandom_range(9)))};
                default: w = {w, "_"};
            endcase
        if (dig(w[0])) w = {"x", w};
        return w;
    endfunction

    function automatic string rand_fragment();
        string ops [12] = '{"<", ">", "=", "<>", "<=", ">=", "==", "/*", "*/", "/", "*",
                            ","};
        string f;
        case ($urandom_range(9))
            0, 1: begin
                f = kw_names[$urandom_range(KW_NUM - 1)];
                if ($urandom_range(1)) f = f.tolower();
            end
            2: f = rand_word();
            3: begin
                f = $sformatf("%0d", $urandom_range(9999));
                if ($urandom_range(1)) f = {f, ".", $sformatf("%0d", $urandom_range(99))};
                case ($urandom_range(4))
                    0: f = {f, "e", $sformatf("%0d", $urandom_range(99))};
                    1: f = {f, "E-", $sformatf("%0d", $urandom_range(9))};
                    2: f = {f, "e+"};
                    3: f = {f, "e"};
                    default: ;
                endcase
            end
            4: f = ops[$urandom_range(11)];
            5: begin
                f = "'";
                repeat ($urandom_range(4))
                    case ($urandom_range(3))
                        0: f = {f, "\\'"};
                        1: f = {f, "\\\\"};
                        default: f = {f, string'(8'($urandom_range(32, 126)))};
                    endcase
                if (f[f.len() - 1] == "\\") f = {f, "n"};
                if ($urandom_range(7)) f = {f, "'"};
            end
            6: f = {"@", rand_word()};
            7: f = string'(8'($urandom_range(1, 255)));
            default: f = " ";
        endcase
        return f;
    endfunction

    task automatic test_random(int items);
        string t;
        int    sent;
        sent = 0;
        while (sent < items) begin
            t = "";
            while (t.len() < $urandom_range(4, 24)) begin
                t = {t, rand_fragment()};
                if ($urandom_range(2) == 0) t = {t, " "};
            end
            send_text(t, $urandom_range(1));
            sent += t.len();
        end
    endtask

    initial begin
        fails        = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        lx_mode      = M_IDLE;
        lx_wlen      = 0;
        lx_tstart    = 0;
        lx_pos       = 0;
        lx_esc       = 1'b0;
        lx_pend[0]   = 8'd0;
        lx_pend[1]   = 8'd0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = 8'd0;
        i_s_tlast    = 1'b0;
        i_m_tready   = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_keywords();
        test_operators();
        test_numbers();
        test_strings();
        drain();

        idle_pct  = 0;  stall_pct = 0;
        test_random(6);
        idle_pct  = 84; stall_pct = 0;
        test_random(6);
        idle_pct  = 0;  stall_pct = 84;
        test_random(6);
        idle_pct  = 7;  stall_pct = 7;
        test_random(6);
        drain();

        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
